// ----- rtl/max_flow_augmenting_path_defines.svh -----
// ----------------------------------------------------------------------------
// Max flow assertion macros
// Concurrent assertion helpers, removed in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_AUGMENTING_PATH_DEFINES_SVH
`define MAX_FLOW_AUGMENTING_PATH_DEFINES_SVH
`ifndef SYNTH
`define MF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define MF_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define MF_ASSERT(label, clk, rst, prop)
`define MF_ASSERT_NR(label, clk, prop)
`endif
`endif

// ----- rtl/mfap_pkg.sv -----
// ----------------------------------------------------------------------------
// Max flow package
// Shared constants and state encoding for the max flow block.
// ----------------------------------------------------------------------------
package mfap_pkg;
   localparam int VERTEX_COUNT = 16;
   localparam int VW           = 4;
   localparam int RW           = 20;
   localparam int FW           = 24;
   localparam int AW           = 2 * VW;
   localparam logic [RW-1:0] RES_MAX  = '1;
   localparam logic [FW-1:0] FLOW_MAX = '1;
   localparam logic CSR_SOURCE = 1'b0;
   localparam logic CSR_SINK   = 1'b1;

   typedef enum logic [3:0] {
      ST_LOAD, ST_LOADWR, ST_BFS_INIT, ST_BFS_POP, ST_BFS_SCAN, ST_BN_RD, ST_BN_CMP,
      ST_AUG_RD, ST_AUG_FWD, ST_AUG_REV, ST_AUG_WB, ST_DONE, ST_CLEAR
   } state_type;
endpackage

// ----- rtl/max_flow_augmenting_path.sv -----
// ----------------------------------------------------------------------------
// Max flow augmenting path
// Edmonds-Karp maximum flow over a residual capacity memory.
// ----------------------------------------------------------------------------
// Each edge beat reads its residual entry in the single-port 256 x 20 memory
// in ST_LOAD and writes it back in ST_LOADWR. The beat marked last starts
// the solve. Every breadth-first search pops each vertex in ST_BFS_POP and
// then reads one residual entry per cycle, 16 per popped vertex.
// Every augmentation walks the path twice: through ST_BN_RD and ST_BN_CMP
// for each arc to find the bottleneck, then through ST_AUG_RD, ST_AUG_FWD,
// ST_AUG_REV and ST_AUG_WB for each arc to update the forward and reverse
// entries. The result beat waits in an output register, so the next graph can
// load while it waits. A finished solve stays in the done state until that
// register is free. After the result is registered, and after reset, a
// clearing pass of 256 writes in ST_CLEAR empties the memory before the next
// edge is taken.
`include "max_flow_augmenting_path_defines.svh"
module max_flow_augmenting_path
   import mfap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // from_node[3:0], to_node[7:4], edge_capacity[23:8]
   input  logic        req_tlast,   // last_edge
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // max_flow[23:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data
);
   state_type state_ff, state_in;
   logic [RW-1:0] mem [VERTEX_COUNT*VERTEX_COUNT];
   logic [RW-1:0] rd_ff;
   logic [AW-1:0] addr;
   logic          we;
   logic [RW-1:0] wdata;

   logic [VW-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [VW-1:0] ef_ff, ef_in, et_ff, et_in;
   logic [15:0]   ecap_ff, ecap_in;
   logic          elast_ff, elast_in;
   logic [VW-1:0] par [VERTEX_COUNT];
   logic [VW-1:0] que [VERTEX_COUNT];
   logic [VERTEX_COUNT-1:0] seen_ff, seen_in;
   logic [VW:0]   head_ff, head_in, tail_ff, tail_in;
   logic [VW-1:0] u_ff, u_in, v_ff, v_in;
   logic [VW-1:0] w_ff, w_in;
   logic [RW-1:0] bn_ff, bn_in;
   logic [FW-1:0] flow_ff, flow_in;
   logic [AW:0]   clr_ff, clr_in;
   logic          out_v_ff, out_v_in;
   logic [FW-1:0] out_d_ff, out_d_in;
   logic          par_we, que_we;
   logic [VW-1:0] p_w;
   logic [RW:0]   sum;
   logic [FW:0]   fsum;

   assign p_w = par[w_ff];
   assign req_tready = (state_ff == ST_LOAD);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rd_ff <= mem[addr];
      if (par_we) par[v_ff] <= u_ff;
      if (que_we) que[tail_ff[VW-1:0]] <= v_ff;
      if (state_ff == ST_BFS_INIT) begin
         par[src_ff] <= src_ff;
         que[0] <= src_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:     if (req_tvalid && req_tready) state_in = ST_LOADWR;
         ST_LOADWR:   state_in = elast_ff ? ((src_ff == dst_ff) ? ST_DONE : ST_BFS_INIT)
                                          : ST_LOAD;
         ST_BFS_INIT: state_in = ST_BFS_POP;
         ST_BFS_POP:  if (seen_ff[dst_ff]) state_in = ST_BN_RD;
                      else if (head_ff >= tail_ff) state_in = ST_DONE;
                      else state_in = ST_BFS_SCAN;
         ST_BFS_SCAN: if (v_ff == VW'(VERTEX_COUNT-1)) state_in = ST_BFS_POP;
         ST_BN_RD:    state_in = ST_BN_CMP;
         ST_BN_CMP:   state_in = (p_w == src_ff) ? ST_AUG_RD : ST_BN_RD;
         ST_AUG_RD:   state_in = ST_AUG_FWD;
         ST_AUG_FWD:  state_in = ST_AUG_REV;
         ST_AUG_REV:  state_in = ST_AUG_WB;
         ST_AUG_WB:   state_in = (p_w == src_ff) ? ST_BFS_INIT : ST_AUG_RD;
         ST_DONE:     if (!out_v_ff) state_in = ST_CLEAR;
         ST_CLEAR:    if (clr_ff[AW]) state_in = ST_LOAD;
         default:     state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      src_in = src_ff; dst_in = dst_ff;
      if (csr_valid && csr_index == CSR_SOURCE) src_in = csr_data;
      if (csr_valid && csr_index == CSR_SINK)   dst_in = csr_data;
      ef_in = ef_ff; et_in = et_ff; ecap_in = ecap_ff; elast_in = elast_ff;
      seen_in = seen_ff; head_in = head_ff; tail_in = tail_ff;
      u_in = u_ff; v_in = v_ff; w_in = w_ff; bn_in = bn_ff; flow_in = flow_ff;
      clr_in = clr_ff; out_v_in = out_v_ff && !rsp_tready; out_d_in = out_d_ff;
      addr = {ef_ff, et_ff}; we = 1'b0; wdata = rd_ff;
      par_we = 1'b0; que_we = 1'b0;
      sum = {1'b0, rd_ff} + {1'b0, bn_ff};
      fsum = {1'b0, flow_ff} + {{(FW-RW+1){1'b0}}, bn_ff};
      unique case (state_ff)
         ST_LOAD: begin
            ef_in = req_tdata[3:0]; et_in = req_tdata[7:4];
            ecap_in = req_tdata[23:8]; elast_in = req_tlast;
            addr = {req_tdata[3:0], req_tdata[7:4]};
            flow_in = '0;
         end
         ST_LOADWR: begin
            we = 1'b1;
            sum = {1'b0, rd_ff} + {{(RW-15){1'b0}}, ecap_ff};
            wdata = sum[RW] ? RES_MAX : sum[RW-1:0];
         end
         ST_BFS_INIT: begin
            seen_in = '0; seen_in[src_ff] = 1'b1;
            head_in = '0; tail_in = (VW+1)'(1);
         end
         ST_BFS_POP: begin
            u_in = que[head_ff[VW-1:0]];
            head_in = head_ff + 1'b1;
            v_in = '0;
            addr = {que[head_ff[VW-1:0]], VW'(0)};
            w_in = dst_ff; bn_in = RES_MAX;
         end
         ST_BFS_SCAN: begin
            addr = {u_ff, v_ff + 1'b1};
            v_in = v_ff + 1'b1;
            if (!seen_ff[v_ff] && rd_ff != '0) begin
               seen_in[v_ff] = 1'b1;
               par_we = 1'b1;
               if (!tail_ff[VW]) begin
                  que_we = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
            end
         end
         ST_BN_RD: addr = {p_w, w_ff};
         ST_BN_CMP: begin
            if (rd_ff < bn_ff) bn_in = rd_ff;
            w_in = p_w;
            if (p_w == src_ff) w_in = dst_ff;
         end
         ST_AUG_RD: addr = {p_w, w_ff};
         ST_AUG_FWD: begin
            addr = {p_w, w_ff}; we = 1'b1; wdata = rd_ff - bn_ff;
         end
         ST_AUG_REV: addr = {w_ff, p_w};
         ST_AUG_WB: begin
            addr = {w_ff, p_w}; we = 1'b1;
            wdata = sum[RW] ? RES_MAX : sum[RW-1:0];
            w_in = p_w;
            if (p_w == src_ff) flow_in = fsum[FW] ? FLOW_MAX : fsum[FW-1:0];
         end
         ST_DONE: begin
            clr_in = '0;
            if (!out_v_ff) begin
               out_v_in = 1'b1; out_d_in = flow_ff;
            end
         end
         ST_CLEAR: begin
            addr = clr_ff[AW-1:0]; we = !clr_ff[AW]; wdata = '0;
            clr_in = clr_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; src_ff <= '0; dst_ff <= VW'(15);
         out_v_ff <= 1'b0; clr_ff <= '0; flow_ff <= '0; bn_ff <= RES_MAX;
      end else begin
         state_ff <= state_in; src_ff <= src_in; dst_ff <= dst_in;
         out_v_ff <= out_v_in; clr_ff <= clr_in; flow_ff <= flow_in; bn_ff <= bn_in;
      end
      ef_ff <= ef_in; et_ff <= et_in; ecap_ff <= ecap_in; elast_ff <= elast_in;
      seen_ff <= seen_in; head_ff <= head_in; tail_ff <= tail_in;
      u_ff <= u_in; v_ff <= v_in; w_ff <= w_in; out_d_ff <= out_d_in;
   end

   `MF_ASSERT(a_rsp_valid_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
   `MF_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
   `MF_ASSERT(a_clear_after_rsp, clock, reset, (state_ff == ST_DONE && !out_v_ff) |=> state_ff == ST_CLEAR)
endmodule
